[rtl/core/cvs_pkg.sv]
// ----------------------------------------------------------------------------
// cvs_pkg: shared types and constants of the Cyrillic Vigenere stream unit
// Alphabet bounds, status codes, the queue entry type and the letter map.
// ----------------------------------------------------------------------------
package cvs_pkg;

	// default number of key letters the key store holds
	localparam int KEY_MAX_DEF = 32;

	// depth of the queue between front and back
	localparam int Q_DEPTH = 2;

	// code points of the uppercase and lowercase alphabet bounds
	localparam logic [15:0] UPPER_A_CP  = 16'd1040;
	localparam logic [15:0] UPPER_YA_CP = 16'd1071;
	localparam logic [15:0] LOWER_A_CP  = 16'd1072;
	localparam logic [15:0] LOWER_YA_CP = 16'd1103;

	// uppercase A as an output letter code
	localparam logic [10:0] LETTER_BASE = 11'd1040;

	// item kinds
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	// cipher mode
	localparam logic MODE_ENC = 1'b0;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_KEY   = 3'd1;
	localparam logic [2:0] ST_BAD_TEXT  = 3'd2;
	localparam logic [2:0] ST_KEY_EMPTY = 3'd3;
	localparam logic [2:0] ST_KEY_LONG  = 3'd4;

	// one classified item as it waits in the queue
	typedef struct packed {
		logic       op;
		logic       first;
		logic       is_upper;
		logic       is_lower;
		logic [4:0] idx;
	} entry_t;

	// queue fill flags seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// soft sign and hard sign trade places, yeru stays; the map is its own inverse
	function automatic logic [4:0] swap_soft_hard(input logic [4:0] u);
		logic [4:0] r;
		unique case (u)
			5'd26:   r = 5'd28;
			5'd28:   r = 5'd26;
			default: r = u;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/cyrillic_vigenere_stream_unit.sv]
// ----------------------------------------------------------------------------
// cyrillic_vigenere_stream_unit: Vigenere cipher over a 32-letter alphabet
// Key and text characters in, one ciphered letter and status per item out.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while neither side stalls and gives
// one result beat per item. A result passes through the two-entry queue and
// then the output register that also holds the key store read data. Key
// items with op 0 append a letter to the key (first = 1 starts a new key);
// text items with op 1 are ciphered with the key letter at the running
// position (first = 1 starts a new message). Any status other than zero marks
// the message for dropping. The mode register selects encrypt (0) or decrypt
// (1); the user writes it only while the unit is idle, which the block itself
// does not enforce. The key store needs no clearing after reset.
module cyrillic_vigenere_stream_unit #(
	parameter int KEY_MAX = cvs_pkg::KEY_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] code,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] letter_out,
	output logic [2:0]  status
);

	logic             mode_q;
	logic             push;
	logic             pop;
	cvs_pkg::entry_t  push_entry;
	cvs_pkg::entry_t  pop_entry;
	cvs_pkg::q_stat_t q_stat;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cvs_pkg::MODE_ENC;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	cvs_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.code       (code),
		.first      (first),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	cvs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.q_stat     (q_stat)
	);

	cvs_back #(
		.KEY_MAX (KEY_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.q_valid    (!q_stat.empty),
		.e          (pop_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.letter_out (letter_out),
		.status     (status)
	);

endmodule

[rtl/core/cvs_front.sv]
// ----------------------------------------------------------------------------
// cvs_front: input side of the stream unit
// Accepts input beats, classifies the code point and pushes the entry.
// ----------------------------------------------------------------------------
module cvs_front (
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            op,
	input  logic [15:0]     code,
	input  logic            first,
	input  cvs_pkg::q_stat_t q_stat,
	output logic            push,
	output cvs_pkg::entry_t push_entry
);

	logic [15:0] code_off;

	// hold the input while the queue has no room
	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	// both case ranges share the low five bits of the offset
	assign code_off = code - cvs_pkg::UPPER_A_CP;

	// classify the character
	always_comb begin
		push_entry.op       = op;
		push_entry.first    = first;
		push_entry.is_upper = (code >= cvs_pkg::UPPER_A_CP) && (code <= cvs_pkg::UPPER_YA_CP);
		push_entry.is_lower = (code >= cvs_pkg::LOWER_A_CP) && (code <= cvs_pkg::LOWER_YA_CP);
		push_entry.idx      = cvs_pkg::swap_soft_hard(code_off[4:0]);
	end

endmodule

[rtl/core/cvs_queue.sv]
// ----------------------------------------------------------------------------
// cvs_queue: short queue between front and back
// Holds classified entries so each side can stall on its own.
// ----------------------------------------------------------------------------
module cvs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cvs_pkg::entry_t  push_entry,
	input  logic             pop,
	output cvs_pkg::entry_t  pop_entry,
	output cvs_pkg::q_stat_t q_stat
);

	localparam int DEPTH = cvs_pkg::Q_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cvs_pkg::entry_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_entry    = slot_q[rd_ptr_q];

	// store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			priority if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

endmodule

[rtl/core/cvs_back.sv]
// ----------------------------------------------------------------------------
// cvs_back: execution side of the stream unit
// Updates key store, key count and key position, then ciphers the letter.
// ----------------------------------------------------------------------------
module cvs_back #(
	parameter int KEY_MAX = cvs_pkg::KEY_MAX_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            mode,
	input  logic            q_valid,
	input  cvs_pkg::entry_t e,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [10:0]     letter_out,
	output logic [2:0]      status
);

	localparam int ADDR_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int CNT_W  = $clog2(KEY_MAX + 1);

	logic [4:0]        key_mem [KEY_MAX];
	logic [CNT_W-1:0]  key_count_q;
	logic [ADDR_W-1:0] key_pos_q;

	logic              adv;
	logic [CNT_W-1:0]  cnt_base;
	logic [ADDR_W-1:0] pos_base;
	logic [ADDR_W-1:0] pos_use;
	logic [CNT_W-1:0]  pos_inc;
	logic [ADDR_W-1:0] pos_wrap;
	logic              key_letter;
	logic              text_letter;
	logic [CNT_W-1:0]  cnt_d;
	logic [ADDR_W-1:0] pos_d;
	logic [2:0]        status_d;
	logic              ok_d;
	logic              mem_we;
	logic              mem_re;

	logic              valid_s2;
	logic              ok_s2;
	logic              mode_s2;
	logic [4:0]        idx_s2;
	logic [4:0]        key_s2;
	logic [2:0]        status_s2;
	logic [4:0]        sum;

	// take an entry whenever the output stage is free or drains
	assign adv = !valid_s2 || !out_stall;
	assign pop = q_valid && adv;

	// key and position arithmetic for the entry at the head of the queue
	always_comb begin
		cnt_base    = e.first ? '0 : key_count_q;
		pos_base    = e.first ? '0 : key_pos_q;
		pos_use     = (CNT_W'(pos_base) >= key_count_q) ? '0 : pos_base;
		pos_inc     = CNT_W'(pos_use) + CNT_W'(1);
		pos_wrap    = (pos_inc >= key_count_q) ? '0 : pos_inc[ADDR_W-1:0];
		key_letter  = e.is_upper || e.is_lower;
		text_letter = e.is_upper || ((mode == cvs_pkg::MODE_ENC) && e.is_lower);

		cnt_d    = key_count_q;
		pos_d    = key_pos_q;
		status_d = cvs_pkg::ST_OK;
		ok_d     = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;

		if (pop) begin
			unique case (e.op)
				cvs_pkg::OP_KEY: begin
					priority if (!key_letter) begin
						cnt_d    = '0;
						status_d = cvs_pkg::ST_BAD_KEY;
					end else if (cnt_base >= CNT_W'(KEY_MAX)) begin
						cnt_d    = '0;
						status_d = cvs_pkg::ST_KEY_LONG;
					end else begin
						mem_we = 1'b1;
						cnt_d  = cnt_base + CNT_W'(1);
					end
				end
				cvs_pkg::OP_TEXT: begin
					pos_d = pos_base;
					priority if (key_count_q == '0) begin
						status_d = cvs_pkg::ST_KEY_EMPTY;
					end else if (!text_letter) begin
						status_d = cvs_pkg::ST_BAD_TEXT;
					end else begin
						ok_d   = 1'b1;
						mem_re = 1'b1;
						pos_d  = pos_wrap;
					end
				end
			endcase
		end
	end

	// key store write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[cnt_base[ADDR_W-1:0]] <= e.idx;
		end
		if (mem_re) begin
			key_s2 <= key_mem[pos_use];
		end
	end

	// key count, position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			key_pos_q   <= '0;
			valid_s2    <= 1'b0;
		end else begin
			key_count_q <= cnt_d;
			key_pos_q   <= pos_d;
			if (adv) begin
				valid_s2 <= pop;
			end
		end
	end

	// output stage payload
	always_ff @(posedge clk) begin
		if (pop) begin
			ok_s2     <= ok_d;
			mode_s2   <= mode;
			idx_s2    <= e.idx;
			status_s2 <= status_d;
		end
	end

	// add or subtract the key letter modulo 32 and map back
	assign sum        = (mode_s2 == cvs_pkg::MODE_ENC) ? idx_s2 + key_s2 : idx_s2 - key_s2;
	assign letter_out = ok_s2 ? cvs_pkg::LETTER_BASE + 11'(cvs_pkg::swap_soft_hard(sum)) : '0;
	assign status     = status_s2;
	assign out_valid  = valid_s2;

endmodule

[rtl/core/cvs_checker.sv]
// ----------------------------------------------------------------------------
// cvs_checker: port-level checks of the stream unit
// Watches result beats for consistent letter and status values.
// ----------------------------------------------------------------------------
module cvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [10:0] letter_out,
	input logic [2:0]  status
);

	// a beat with an error status carries no letter
	a_err_no_letter: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != cvs_pkg::ST_OK) |-> (letter_out == '0))
		else $error("error beat carries a letter");

	// a letter is always an uppercase code point
	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && letter_out != '0) |->
		(letter_out >= 11'd1040 && letter_out <= 11'd1071))
		else $error("letter outside the uppercase range");

	// status is one of the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= cvs_pkg::ST_KEY_LONG))
		else $error("undefined status code");

	// a stalled beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(letter_out) && $stable(status)))
		else $error("stalled result beat changed");

endmodule

bind cyrillic_vigenere_stream_unit cvs_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.letter_out (letter_out),
	.status     (status)
);
